// ----- src/assert_macros.svh -----
// Assertion macros shared by the keyframe table RTL.
// Simulation builds get checks; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- src/kti_pkg.sv -----
// Shared types and constants for the keyframe table interpolator.
// No dependencies.
`default_nettype none
package kti_pkg;
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REPLACED = 2'd1,
        ST_FULL     = 2'd2,
        ST_SAMPLED  = 2'd3
    } op_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_MUL,
        S_DONE
    } fsm_t;

    // request operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam int TimeW  = 16;
    localparam int ValueW = 32;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic shift_right;  // take neighbor's key (insertion shift)
        logic write_new;    // load the new key where marked
        logic write_val;    // replace only the value where marked
    } cell_ctl_t;
endpackage
`default_nettype wire

// ----- src/kti_cell.sv -----
// One keyframe storage cell of the table chain.
// Depends on kti_pkg.
`default_nettype none
module kti_cell (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire kti_pkg::cell_ctl_t ctl,
    input  wire                  sel,
    input  wire                  left_valid,
    input  wire [15:0]           left_time,
    input  wire [31:0]           left_value,
    input  wire [15:0]           new_time,
    input  wire [31:0]           new_value,
    output logic                 valid,
    output logic [15:0]          key_time,
    output logic [31:0]          key_value
);
    import kti_pkg::*;

    logic        valid_reg;
    logic [15:0] time_reg;
    logic [31:0] value_reg;

    // valid bit marks occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.write_new && sel)
        begin
            valid_reg <= 1'b1;
        end
        else if (ctl.shift_right)
        begin
            valid_reg <= valid_reg | left_valid;
        end
    end

    // payload: shift from the left neighbor, load new key, or replace value
    always_ff @(posedge clk)
    begin
        if (ctl.write_new && sel)
        begin
            time_reg  <= new_time;
            value_reg <= new_value;
        end
        else if (ctl.write_val && sel)
        begin
            value_reg <= new_value;
        end
        else if (ctl.shift_right)
        begin
            time_reg  <= left_time;
            value_reg <= left_value;
        end
    end

    assign valid     = valid_reg;
    assign key_time  = time_reg;
    assign key_value = value_reg;
endmodule
`default_nettype wire

// ----- src/kti_div.sv -----
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on kti_pkg.
`default_nettype none
module kti_div (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    input  wire  [47:0] dividend,
    input  wire  [15:0] divisor,
    output logic        done,
    output logic [47:0] quotient
);
    import kti_pkg::*;

    logic [47:0] q_reg;
    logic [16:0] r_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [16:0] r_shift;
    logic [16:0] r_sub;

    always_comb
    begin
        r_shift = {r_reg[15:0], q_reg[47]};
        r_sub   = r_shift - {1'b0, divisor};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd47)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    // one bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!r_sub[16])
            begin
                r_reg <= r_sub;
                q_reg <= {q_reg[46:0], 1'b1};
            end
            else
            begin
                r_reg <= r_shift;
                q_reg <= {q_reg[46:0], 1'b0};
            end
        end
    end

    assign quotient = q_reg;
endmodule
`default_nettype wire

// ----- src/keyframe_table_interpolator_unit.sv -----
// Keyframe table interpolator: insert and sample over a sorted cell chain.
// Inserts and end-value samples go from the scan state straight to the result
// strobe; interpolating samples pass through the bit-serial divider first. busy drops
// the cycle after the strobe, so a new request is taken only once the last is done.
// Receiver cannot stall. Reset: async active low clears the cell valid bits
// and the sequencer.
`default_nettype none
`include "assert_macros.svh"
module keyframe_table_interpolator_unit #(
    parameter int MAX_KEYS = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire         func,
    input  wire  [15:0] frame_time,
    input  wire  signed [31:0] key_value,
    output logic        done,
    output logic signed [31:0] sample_value,
    output logic        has_value,
    output logic [1:0]  op_status
);
    import kti_pkg::*;

    localparam int N = MAX_KEYS;

    fsm_t state_reg, state_next;
    logic        func_reg;
    logic [15:0] t_reg;
    logic [31:0] v_reg;

    logic [N-1:0]  vld;
    logic [15:0]   kt [N];
    logic [31:0]   kv [N];
    logic [N-1:0]  sel;
    cell_ctl_t     ctl [N];

    // scan results, registered
    logic [N-1:0]  match, ge;
    logic [N-1:0]  rep_sel, ins_sel;
    logic          any_match, full;
    logic [N-1:0]  rep_sel_reg, ins_sel_reg;
    logic [1:0]    kind_reg;    // insert outcome code
    logic          empty_reg, hold_reg;
    logic [31:0]   hold_val_reg;
    logic signed [31:0] vs_reg, ve_reg;
    logic [15:0]   dt_reg, den_reg;
    logic signed [32:0] dv_reg;
    logic          neg_reg;
    logic          div_start;
    logic          div_done;
    logic [47:0]   quo;
    logic signed [31:0] res_reg;

    // cell chain
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        kti_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl[i]),
            .sel        (sel[i]),
            .left_valid ((i == 0) ? 1'b0  : vld[(i == 0) ? 0 : i-1]),
            .left_time  ((i == 0) ? 16'd0 : kt[(i == 0) ? 0 : i-1]),
            .left_value ((i == 0) ? 32'd0 : kv[(i == 0) ? 0 : i-1]),
            .new_time   (t_reg),
            .new_value  (v_reg),
            .valid      (vld[i]),
            .key_time   (kt[i]),
            .key_value  (kv[i])
        );
    end

    // per-cell comparisons against the request time
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            match[i] = vld[i] && (kt[i][15:6] == t_reg[15:6]);
            ge[i]    = vld[i] && (kt[i] >= t_reg);
        end
        // first match before the insertion point: prefix of keys with t > key
        rep_sel   = '0;
        ins_sel   = '0;
        any_match = 1'b0;
        for (int i = 0; i < N; i++)
        begin
            if (!any_match && ins_sel == '0)
            begin
                if (match[i])
                begin
                    rep_sel[i] = 1'b1;
                    any_match  = 1'b1;
                end
                else if (!vld[i] || ge[i])
                begin
                    ins_sel[i] = 1'b1;
                end
            end
        end
        full = vld[N-1];
    end

    // cells left of the insertion point must not shift
    logic [N-1:0] shift_mask;
    always_comb
    begin
        shift_mask = '0;
        for (int i = 1; i < N; i++)
            shift_mask[i] = shift_mask[i-1] | ins_sel_reg[i-1];
    end

    // insert shifts cells past the insertion point; replace writes one value
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            ctl[i] = '0;
            sel[i] = 1'b0;
            if (state_reg == S_DONE && func_reg == FUNC_INSERT)
            begin
                if (kind_reg == ST_REPLACED)
                begin
                    ctl[i].write_val = 1'b1;
                    sel[i]           = rep_sel_reg[i];
                end
                else if (kind_reg == ST_INSERTED)
                begin
                    ctl[i].shift_right = shift_mask[i];
                    ctl[i].write_new   = 1'b1;
                    sel[i]             = ins_sel_reg[i];
                end
            end
        end
    end

    // sample bracket: first cell with key >= t
    logic [N-1:0] first_ge;
    logic         seen;
    logic [31:0]  pick_ve, pick_vs, last_v;
    logic [15:0]  pick_te, pick_ts;
    logic         at_first, past_last;
    always_comb
    begin
        first_ge = '0;
        seen     = 1'b0;
        pick_ve  = '0;
        pick_vs  = '0;
        pick_te  = '0;
        pick_ts  = '0;
        last_v   = '0;
        for (int i = 0; i < N; i++)
        begin
            if (vld[i])
                last_v = kv[i];
            if (!seen && ge[i])
            begin
                first_ge[i] = 1'b1;
                seen        = 1'b1;
                pick_ve     = kv[i];
                pick_te     = kt[i];
                if (i > 0)
                begin
                    pick_vs = kv[(i > 0) ? i-1 : 0];
                    pick_ts = kt[(i > 0) ? i-1 : 0];
                end
            end
        end
        at_first  = first_ge[0];
        past_last = !seen;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (start) state_next = S_SCAN;
            S_SCAN:
            begin
                if (func_reg == FUNC_INSERT || !vld[0] || past_last || at_first)
                    state_next = S_DONE;
                else
                    state_next = S_DIV;
            end
            S_DIV:  if (div_done) state_next = S_MUL;
            S_MUL:  state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        busy      = (state_reg != S_IDLE);
        div_start = (state_reg == S_SCAN) && (state_next == S_DIV);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // request and scan registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            func_reg <= func;
            t_reg    <= frame_time;
            v_reg    <= key_value;
        end
        if (state_reg == S_SCAN)
        begin
            rep_sel_reg  <= rep_sel;
            ins_sel_reg  <= ins_sel;
            if (any_match)
                kind_reg <= ST_REPLACED;
            else if (full)
                kind_reg <= ST_FULL;
            else
                kind_reg <= ST_INSERTED;
            empty_reg    <= !vld[0];
            hold_reg     <= past_last || at_first;
            hold_val_reg <= past_last ? last_v : kv[0];
            vs_reg       <= pick_vs;
            ve_reg       <= pick_ve;
            dt_reg       <= t_reg - pick_ts;
            den_reg      <= pick_te - pick_ts;
            dv_reg       <= $signed({pick_ve[31], pick_ve}) - $signed({pick_vs[31], pick_vs});
            neg_reg      <= pick_ve[31] ^ pick_vs[31] ?
                            pick_vs[31] == 1'b0 : $signed(pick_ve) < $signed(pick_vs);
        end
        if (state_reg == S_MUL)
            res_reg <= neg_reg ? vs_reg - quo[31:0] : vs_reg + quo[31:0];
    end

    // magnitude product |dv| * dt, at most 33x16 bits
    logic [32:0] dv_mag;
    assign dv_mag = dv_reg[32] ? 33'(-dv_reg) : 33'(dv_reg);

    logic [47:0] prod;
    assign prod = 48'(dv_mag) * 48'(dt_reg);

    logic div_go_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_go_reg <= 1'b0;
        else
            div_go_reg <= div_start;
    end

    kti_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .dividend (prod),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (quo)
    );

    // result strobe
    always_comb
    begin
        done         = (state_reg == S_DONE);
        sample_value = '0;
        has_value    = 1'b0;
        op_status    = ST_SAMPLED;
        if (func_reg == FUNC_INSERT)
        begin
            op_status = kind_reg;
        end
        else if (!empty_reg)
        begin
            has_value    = 1'b1;
            sample_value = hold_reg ? hold_val_reg : res_reg;
        end
    end

    `ASSERT_IMPL(a_done_one_cycle, clk, rst_n, done |=> !done)
    `ASSERT_IMPL(a_busy_on_start, clk, rst_n, (start && !busy) |=> busy)
    `ASSERT_NEVER(a_idle_no_div, clk, rst_n, (state_reg == S_IDLE) && div_done)
endmodule
`default_nettype wire

// ----- test/keyframe_table_interpolator_unit_check.sv -----
// Checker for the keyframe table interpolator: tracks the key table, predicts
// each result and compares it with the block's output. Depends on kti_pkg.
`timescale 1ns / 1ps
module keyframe_table_interpolator_unit_check #(
    parameter int MAX_KEYS = 16
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    input  wire               busy,
    input  wire               func,
    input  wire        [15:0] frame_time,
    input  wire signed [31:0] key_value,
    input  wire               done,
    input  wire signed [31:0] sample_value,
    input  wire               has_value,
    input  wire         [1:0] op_status,
    output int                mismatches,
    output int                outstanding
);
    import kti_pkg::*;

    typedef struct {
        logic signed [31:0] value;
        logic               valid;
        op_status_t         status;
    } key_result_t;

    // Shadow copy of the key table
    logic        [15:0] shadow_times [MAX_KEYS];
    logic signed [31:0] shadow_values[MAX_KEYS];
    int                 shadow_count;
    key_result_t        pending_results[$];

    // Insert into sorted place, replace on a whole-frame match
    function automatic op_status_t insert_key(logic [15:0] t, logic signed [31:0] v);
        int i;
        int j;
        i = 0;
        while (i < shadow_count) begin
            if (shadow_times[i][15:6] == t[15:6]) begin
                shadow_values[i] = v;
                return ST_REPLACED;
            end
            if (t <= shadow_times[i])
                break;
            i++;
        end
        if (shadow_count >= MAX_KEYS)
            return ST_FULL;
        for (j = shadow_count; j > i; j--) begin
            shadow_times[j]  = shadow_times[j - 1];
            shadow_values[j] = shadow_values[j - 1];
        end
        shadow_times[i]  = t;
        shadow_values[i] = v;
        shadow_count++;
        return ST_INSERTED;
    endfunction

    // Held end values or linear interpolation between bracketing keys
    function automatic logic signed [31:0] interpolate_at(logic [15:0] t);
        int          i;
        longint      vs;
        longint      ve;
        longint      span;
        longint      prod;
        longint      sum;
        int          last;
        last = shadow_count - 1;
        if (shadow_count == 1 || t >= shadow_times[last])
            return shadow_values[last];
        if (t <= shadow_times[0])
            return shadow_values[0];
        i = 1;
        while (i < last && shadow_times[i] < t)
            i++;
        vs   = shadow_values[i - 1];
        ve   = shadow_values[i];
        span = longint'(shadow_times[i]) - longint'(shadow_times[i - 1]);
        if (span <= 0)
            return shadow_values[i];
        prod = (ve - vs) * (longint'(t) - longint'(shadow_times[i - 1]));
        sum  = vs + prod / span;
        return sum[31:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        key_result_t expected;
        if (!rst_n) begin
            shadow_count = 0;
            mismatches   = 0;
            pending_results.delete();
        end else begin
            // Compare a result with the oldest expectation
            if (done) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: value=%0d has=%0b status=%0d",
                                 sample_value, has_value, op_status);
                end else begin
                    expected = pending_results.pop_front();
                    if (sample_value !== expected.value || has_value !== expected.valid ||
                        op_status !== expected.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp value=%0d has=%0b status=%0d, got value=%0d has=%0b status=%0d",
                                     expected.value, expected.valid, expected.status,
                                     sample_value, has_value, op_status);
                    end
                end
            end
            // Predict an accepted request
            if (start && !busy) begin
                expected.value = '0;
                expected.valid = 1'b0;
                if (func == FUNC_INSERT) begin
                    expected.status = insert_key(frame_time, key_value);
                end else begin
                    expected.status = ST_SAMPLED;
                    if (shadow_count != 0) begin
                        expected.value = interpolate_at(frame_time);
                        expected.valid = 1'b1;
                    end
                end
                pending_results.insert(pending_results.size(), expected);
            end
        end
        outstanding = pending_results.size();
    end
endmodule

// ----- test/keyframe_table_interpolator_unit_test.sv -----
// Testbench top for the keyframe table interpolator: drives insert and sample
// requests and gives the verdict. Depends on kti_pkg, the block and the checker.
`timescale 1ns / 1ps
module keyframe_table_interpolator_unit_test;
    import kti_pkg::*;

    localparam int   STALL_LIMIT = 20000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               func = FUNC_INSERT;
    logic        [15:0] frame_time = '0;
    logic signed [31:0] key_value = '0;
    wire                busy;
    wire                done;
    wire signed  [31:0] sample_value;
    wire                has_value;
    wire          [1:0] op_status;
    int                 mismatches;
    int                 outstanding;
    int                 idle_pct;
    int                 quiet_cycles;

    always #2 clk = ~clk;

    keyframe_table_interpolator_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .frame_time(frame_time), .key_value(key_value), .done(done),
        .sample_value(sample_value), .has_value(has_value), .op_status(op_status)
    );

    keyframe_table_interpolator_unit_check check (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .frame_time(frame_time), .key_value(key_value), .done(done),
        .sample_value(sample_value), .has_value(has_value), .op_status(op_status),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    // Watchdog on cycles with no request or result moving
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Issue one request, with a random idle gap first
    task automatic send_request(logic f, logic [15:0] t, logic signed [31:0] v);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        start      <= 1'b1;
        func       <= f;
        frame_time <= t;
        key_value  <= v;
        // busy only moves at rising edges, so check it mid-cycle
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
    endtask

    // Mostly a small pool of whole frames so keys collide and get replaced
    function automatic logic [15:0] pick_time();
        if ($urandom_range(4) == 0)
            return 16'($urandom());
        return {6'($urandom_range(0, 1)), 4'($urandom_range(15)), 6'($urandom_range(63))};
    endfunction

    initial begin
        idle_pct     = 0;
        quiet_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, extremes, replace, before/after/between keys
        send_request(FUNC_SAMPLE, 16'h1234, 32'sh7fff_ffff);
        send_request(FUNC_INSERT, 16'h0040, 32'sh7fff_ffff);
        send_request(FUNC_SAMPLE, 16'h0000, 32'sd0);
        send_request(FUNC_SAMPLE, 16'hffff, 32'sd0);
        send_request(FUNC_INSERT, 16'hffff, -32'sh8000_0000);
        send_request(FUNC_SAMPLE, 16'h8000, 32'sd0);
        send_request(FUNC_SAMPLE, 16'hffff, 32'sd0);
        send_request(FUNC_SAMPLE, 16'h0000, 32'sd0);
        send_request(FUNC_SAMPLE, 16'h0041, 32'sd0);
        send_request(FUNC_INSERT, 16'h007f, 32'sd12345);
        send_request(FUNC_INSERT, 16'h0000, 32'sd0);
        send_request(FUNC_SAMPLE, 16'h0020, 32'sd0);
        send_request(FUNC_SAMPLE, 16'h0001, 32'sd0);
        send_request(FUNC_INSERT, 16'h0080, -32'sd1);
        send_request(FUNC_SAMPLE, 16'h0060, 32'sd0);
        send_request(FUNC_SAMPLE, 16'hfffe, 32'sd0);
        send_request(FUNC_INSERT, 16'hffc0, 32'sh0001_0000);
        send_request(FUNC_SAMPLE, 16'hffe0, 32'sd0);

        // Random phases: no idling, heavy idling, none, moderate idling
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1) ? 85 : (phase == 3) ? 28 : 0;
            for (int n = 0; n < 150; n++)
                send_request($urandom_range(99) < 55 ? FUNC_SAMPLE : FUNC_INSERT,
                             pick_time(), 32'($urandom()));
        end
        start <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+src
src/kti_pkg.sv
src/kti_cell.sv
src/kti_div.sv
src/keyframe_table_interpolator_unit.sv
test/keyframe_table_interpolator_unit_check.sv
test/keyframe_table_interpolator_unit_test.sv
